@@ hw/rtl/first_match_packet_rule_classifier_core_assert.svh @@
// Assertion macros for the rule classifier core.
// Used by the top level; expects clk and arst_n in scope.
`ifndef FIRST_MATCH_PACKET_RULE_CLASSIFIER_CORE_ASSERT_SVH
`define FIRST_MATCH_PACKET_RULE_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FMPC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fmpc assertion failed");

// next-cycle implication, checked out of reset
`define FMPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fmpc assertion failed");

`endif

@@ hw/rtl/fmpc_pkg.sv @@
// Shared types, codes and sizes for the rule classifier.
// No dependencies.
package fmpc_pkg;

	localparam int MAX_RULES = 64;
	localparam int RULE_W = $clog2(MAX_RULES);
	localparam int CNT_W = $clog2(MAX_RULES + 1);
	localparam logic [15:0] PORT_LIMIT = 16'd1023;

	typedef enum logic {
		OP_CLASSIFY = 1'b0,
		OP_WRITE = 1'b1
	} opcode_t;

	typedef enum logic [3:0] {
		FS_DIR_MASK = 4'd0,
		FS_SRC_ADDR = 4'd1,
		FS_SRC_MASK = 4'd2,
		FS_DST_ADDR = 4'd3,
		FS_DST_MASK = 4'd4,
		FS_PROTO = 4'd5,
		FS_SP_MODE = 4'd6,
		FS_SP_VAL = 4'd7,
		FS_DP_MODE = 4'd8,
		FS_DP_VAL = 4'd9,
		FS_ACK_MODE = 4'd10,
		FS_ACTION = 4'd11
	} fsel_t;

	// rule protocol codes; packets are mapped onto the same codes
	typedef enum logic [1:0] {
		PR_ANY = 2'd0,
		PR_TCP = 2'd1,
		PR_UDP = 2'd2,
		PR_ICMP = 2'd3
	} proto_t;

	typedef enum logic [1:0] {
		PM_ANY = 2'd0,
		PM_ABOVE = 2'd1,
		PM_EXACT = 2'd2,
		PM_EXACT_ALT = 2'd3
	} pmode_t;

	typedef enum logic [1:0] {
		AM_ANY = 2'd0,
		AM_SET = 2'd1,
		AM_CLEAR = 2'd2,
		AM_ANY_ALT = 2'd3
	} ackmode_t;

	typedef enum logic [1:0] {
		RS_MATCHED = 2'd0,
		RS_NO_MATCH = 2'd1,
		RS_XMAS = 2'd2,
		RS_NOT_INSPECTED = 2'd3
	} reason_t;

	localparam logic [7:0] IPPROTO_ICMP = 8'd1;
	localparam logic [7:0] IPPROTO_TCP = 8'd6;
	localparam logic [7:0] IPPROTO_UDP = 8'd17;

	localparam int FL_FIN = 0;
	localparam int FL_PSH = 3;
	localparam int FL_ACK = 4;
	localparam int FL_URG = 5;

	typedef struct packed {
		logic opcode;
		logic [5:0] rule_slot;
		logic [3:0] field_select;
		logic [31:0] field_value;
		logic [1:0] pkt_direction;
		logic [31:0] src_address;
		logic [31:0] dst_address;
		logic [7:0] ip_protocol;
		logic [15:0] src_port_num;
		logic [15:0] dst_port_num;
		logic [5:0] tcp_flag_bits;
	} in_beat_t;

	typedef struct packed {
		logic verdict;
		logic [1:0] reason;
		logic [5:0] matched_rule;
	} out_beat_t;

	// item as it travels down the cell chain
	typedef struct packed {
		logic is_write;
		logic [5:0] slot;
		logic [3:0] sel;
		logic [31:0] value;
		logic outbound;
		logic [31:0] sa;
		logic [31:0] da;
		logic [1:0] proto;
		logic [15:0] sp;
		logic [15:0] dp;
		logic ack;
		logic done;
		logic verdict;
		logic [1:0] reason;
		logic [5:0] matched;
	} stage_t;

endpackage

@@ hw/rtl/fmpc_in_if.sv @@
// Input channel: valid/ready handshake carrying one header or rule-write beat.
// Depends on fmpc_pkg.
interface fmpc_in_if;
	logic valid;
	logic ready;
	fmpc_pkg::in_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/fmpc_out_if.sv @@
// Result channel: valid/ready handshake carrying one verdict beat.
// Depends on fmpc_pkg.
interface fmpc_out_if;
	logic valid;
	logic ready;
	fmpc_pkg::out_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/fmpc_cell.sv @@
// One rule cell: holds a rule, takes writes aimed at it, and tests passing headers.
// Depends on fmpc_pkg.
module fmpc_cell (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic [fmpc_pkg::RULE_W-1:0] idx,
	input logic [fmpc_pkg::CNT_W-1:0] count,
	input logic up_valid,
	input fmpc_pkg::stage_t up,
	output logic dn_valid,
	output fmpc_pkg::stage_t dn
);

	logic [31:0] src_addr_q, src_mask_q, dst_addr_q, dst_mask_q;
	logic [15:0] sp_val_q, dp_val_q;
	logic [1:0] sp_mode_q, dp_mode_q, dir_mask_q, proto_q, ack_mode_q;
	logic action_q;

	logic dn_valid_q;
	fmpc_pkg::stage_t dn_q;

	logic active, hit, src_ok, dst_ok, proto_ok, sp_ok, dp_ok, ack_ok, port_ok, dir_ok;
	logic wr_hit;
	fmpc_pkg::stage_t nxt;

	assign active = 8'(idx) < 8'(count);
	assign wr_hit = up_valid && up.is_write && (8'(up.slot) == 8'(idx));

	always_comb begin
		dir_ok = up.outbound ? dir_mask_q[1] : dir_mask_q[0];
		src_ok = (src_addr_q == 32'd0) || ((src_mask_q & up.sa) == (src_mask_q & src_addr_q));
		dst_ok = (dst_addr_q == 32'd0) || ((dst_mask_q & up.da) == (dst_mask_q & dst_addr_q));
		proto_ok = (proto_q == fmpc_pkg::PR_ANY) || (proto_q == up.proto);
		case (sp_mode_q)
			fmpc_pkg::PM_ANY: sp_ok = 1'b1;
			fmpc_pkg::PM_ABOVE: sp_ok = up.sp > fmpc_pkg::PORT_LIMIT;
			default: sp_ok = up.sp == sp_val_q;
		endcase
		case (dp_mode_q)
			fmpc_pkg::PM_ANY: dp_ok = 1'b1;
			fmpc_pkg::PM_ABOVE: dp_ok = up.dp > fmpc_pkg::PORT_LIMIT;
			default: dp_ok = up.dp == dp_val_q;
		endcase
		case (ack_mode_q)
			fmpc_pkg::AM_SET: ack_ok = up.ack;
			fmpc_pkg::AM_CLEAR: ack_ok = !up.ack;
			default: ack_ok = 1'b1;
		endcase
		if (up.proto == fmpc_pkg::PR_ICMP) begin
			// ICMP has no ports: any port constraint fails
			port_ok = (sp_mode_q == fmpc_pkg::PM_ANY) && (dp_mode_q == fmpc_pkg::PM_ANY);
		end else if (up.proto == fmpc_pkg::PR_TCP) begin
			port_ok = sp_ok && dp_ok && ack_ok;
		end else begin
			port_ok = sp_ok && dp_ok;
		end
		hit = active && dir_ok && src_ok && dst_ok && proto_ok && port_ok;

		nxt = up;
		if (!up.is_write && !up.done && hit) begin
			nxt.done = 1'b1;
			nxt.verdict = action_q;
			nxt.reason = fmpc_pkg::RS_MATCHED;
			nxt.matched = 6'(idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_valid_q <= 1'b0;
		end else if (adv) begin
			dn_valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dn_q <= nxt;
		end
	end

	// rule storage, no reset: undefined until written
	always_ff @(posedge clk) begin
		if (adv && wr_hit) begin
			case (up.sel)
				fmpc_pkg::FS_DIR_MASK: dir_mask_q <= up.value[1:0];
				fmpc_pkg::FS_SRC_ADDR: src_addr_q <= up.value;
				fmpc_pkg::FS_SRC_MASK: src_mask_q <= up.value;
				fmpc_pkg::FS_DST_ADDR: dst_addr_q <= up.value;
				fmpc_pkg::FS_DST_MASK: dst_mask_q <= up.value;
				fmpc_pkg::FS_PROTO: proto_q <= up.value[1:0];
				fmpc_pkg::FS_SP_MODE: sp_mode_q <= up.value[1:0];
				fmpc_pkg::FS_SP_VAL: sp_val_q <= up.value[15:0];
				fmpc_pkg::FS_DP_MODE: dp_mode_q <= up.value[1:0];
				fmpc_pkg::FS_DP_VAL: dp_val_q <= up.value[15:0];
				fmpc_pkg::FS_ACK_MODE: ack_mode_q <= up.value[1:0];
				fmpc_pkg::FS_ACTION: action_q <= up.value[0];
				default: ;
			endcase
		end
	end

	assign dn_valid = dn_valid_q;
	assign dn = dn_q;

endmodule

@@ hw/rtl/first_match_packet_rule_classifier_core.sv @@
// First-match rule classifier: a chain of MAX_RULES rule cells, one per rule.
// Each accepted beat passes through the cell registers in order, then the result register.
// Throughput: one beat per cycle while the chain is not stalled; each cell tests a header in the cycle it passes.
// The whole chain stalls only while a result waits on a not-ready sink.
// Reset (arst_n low, async): clears rule count and all valid flags; rule
// contents are undefined until written.
module first_match_packet_rule_classifier_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [6:0] cfg_wdata,
	fmpc_in_if.sink pkt_in,
	fmpc_out_if.source res_out
);

	`include "first_match_packet_rule_classifier_core_assert.svh"

	localparam int N = fmpc_pkg::MAX_RULES;

	logic [fmpc_pkg::CNT_W-1:0] count_q;
	logic adv;

	// chain taps: entry [0] is the screened input, entry [i+1] is cell i output
	logic chain_valid [0:N];
	fmpc_pkg::stage_t chain [0:N];

	logic res_valid_q;
	fmpc_pkg::out_beat_t res_q;

	fmpc_pkg::in_beat_t b;
	fmpc_pkg::stage_t entry;
	logic known_proto;
	fmpc_pkg::stage_t last;

	// Rule count register. Values above the table size act as "all rules"
	// since each cell only compares its own index against it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= fmpc_pkg::CNT_W'(cfg_wdata);
		end
	end

	// Chain moves unless a finished result is stuck in the output register.
	assign adv = !(res_valid_q && !res_out.ready);
	assign pkt_in.ready = adv;

	// Screening at chain entry: direction, protocol, then xmas test. Items
	// decided here still travel down the chain with done set, which keeps
	// results in order.
	always_comb begin
		b = pkt_in.data;
		entry = '0;
		entry.is_write = (b.opcode == fmpc_pkg::OP_WRITE);
		entry.slot = b.rule_slot;
		entry.sel = b.field_select;
		entry.value = b.field_value;
		entry.outbound = b.pkt_direction[0];
		entry.sa = b.src_address;
		entry.da = b.dst_address;
		entry.sp = b.src_port_num;
		entry.dp = b.dst_port_num;
		entry.ack = b.tcp_flag_bits[fmpc_pkg::FL_ACK];
		known_proto = 1'b1;
		case (b.ip_protocol)
			fmpc_pkg::IPPROTO_TCP: entry.proto = fmpc_pkg::PR_TCP;
			fmpc_pkg::IPPROTO_UDP: entry.proto = fmpc_pkg::PR_UDP;
			fmpc_pkg::IPPROTO_ICMP: entry.proto = fmpc_pkg::PR_ICMP;
			default: begin
				entry.proto = fmpc_pkg::PR_ANY;
				known_proto = 1'b0;
			end
		endcase
		if (b.pkt_direction[1] || !known_proto) begin
			// unwatched interface (codes 2 and 3) or other protocol
			entry.done = 1'b1;
			entry.verdict = 1'b1;
			entry.reason = fmpc_pkg::RS_NOT_INSPECTED;
		end else if (entry.proto == fmpc_pkg::PR_TCP && b.tcp_flag_bits[fmpc_pkg::FL_FIN]
				&& b.tcp_flag_bits[fmpc_pkg::FL_PSH] && b.tcp_flag_bits[fmpc_pkg::FL_URG]) begin
			entry.done = 1'b1;
			entry.verdict = 1'b0;
			entry.reason = fmpc_pkg::RS_XMAS;
		end
	end

	assign chain_valid[0] = pkt_in.valid;
	assign chain[0] = entry;

	for (genvar i = 0; i < N; i++) begin : g_cell
		fmpc_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.idx(fmpc_pkg::RULE_W'(i)),
			.count(count_q),
			.up_valid(chain_valid[i]),
			.up(chain[i]),
			.dn_valid(chain_valid[i+1]),
			.dn(chain[i+1])
		);
	end

	// End of chain: headers nobody claimed are dropped.
	always_comb begin
		last = chain[N];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			// rule writes leave the chain silently
			res_valid_q <= chain_valid[N] && !last.is_write;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (last.done) begin
				res_q.verdict <= last.verdict;
				res_q.reason <= last.reason;
				res_q.matched_rule <= (last.reason == fmpc_pkg::RS_MATCHED) ? last.matched : 6'd0;
			end else begin
				res_q.verdict <= 1'b0;
				res_q.reason <= fmpc_pkg::RS_NO_MATCH;
				res_q.matched_rule <= 6'd0;
			end
		end
	end

	assign res_out.valid = res_valid_q;
	assign res_out.data = res_q;

	// a stalled result blocks intake
	`FMPC_ASSERT_NOW(a_stall_blocks_intake, res_valid_q && !res_out.ready, !pkt_in.ready)
	// non-match and xmas results always drop and carry rule 0
	`FMPC_ASSERT_NOW(a_drop_codes, res_valid_q && (res_q.reason == fmpc_pkg::RS_NO_MATCH
		|| res_q.reason == fmpc_pkg::RS_XMAS), !res_q.verdict && (res_q.matched_rule == 6'd0))
	// a write leaving the chain never produces a result beat
	`FMPC_ASSERT_NEXT(a_write_silent, adv && chain_valid[N] && last.is_write, !res_valid_q)

endmodule
